// File: design/rftd_pkg.sv
package rftd_pkg;

   // Field and datapath widths.
   localparam int ByteBits  = 8;
   localparam int MagBits   = 15;
   localparam int DistBits  = 16;
   localparam int SqBits    = 2 * MagBits;
   localparam int SumBits   = SqBits + 1;
   localparam int PosBits   = 5;
   localparam int TgtBits   = 2;
   localparam int OffBits   = 3;
   localparam int RootSteps = 16;
   localparam int StepBits  = 4;
   localparam int TgtCount  = 3;

   // Header bytes of a frame.
   localparam logic [ByteBits-1:0] HeaderFirst  = 8'hAA;
   localparam logic [ByteBits-1:0] HeaderSecond = 8'hFF;

   // Frame byte positions.
   localparam logic [PosBits-1:0] FrameLast   = 5'd27;
   localparam logic [PosBits-1:0] TargetFirst = 5'd2;
   localparam logic [PosBits-1:0] TargetEnd   = 5'd26;

   // Byte offsets inside one eight-byte target record.
   localparam logic [OffBits-1:0] OffXLow  = 3'd0;
   localparam logic [OffBits-1:0] OffXHigh = 3'd1;
   localparam logic [OffBits-1:0] OffYLow  = 3'd2;
   localparam logic [OffBits-1:0] OffYHigh = 3'd3;

   // First trial bit of the digit-by-digit square root.
   localparam logic [SumBits-1:0] RootBitFirst = 31'h4000_0000;
   localparam logic [StepBits-1:0] StepLast    = 4'(RootSteps - 1);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_FIRST,
      PH_COLLECT
   } phase_type;

   typedef enum logic [1:0] {
      US_IDLE,
      US_MUL_X,
      US_MUL_Y,
      US_ROOT
   } unit_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

// File: design/rftd_if.sv
interface rftd_req_if;
   logic                           valid;
   logic                           ready;
   logic [rftd_pkg::ByteBits-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rftd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rftd_pkg::DistBits-1:0]  dist_first;
   logic [rftd_pkg::DistBits-1:0]  dist_second;
   logic [rftd_pkg::DistBits-1:0]  dist_third;

   modport source (output valid, output dist_first, output dist_second, output dist_third,
                   input ready);
   modport sink   (input valid, input dist_first, input dist_second, input dist_third,
                   output ready);
endinterface

// File: design/rftd_dist_unit.sv
module rftd_dist_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rftd_pkg::MagBits-1:0]    x_mag,
   input  logic [rftd_pkg::MagBits-1:0]    y_mag,
   output rftd_pkg::unit_stat_type         stat,
   output logic [rftd_pkg::DistBits-1:0]   root_out
);

   rftd_pkg::unit_state_type state_ff, state_in;
   logic                            done_ff, done_in;
   logic [rftd_pkg::MagBits-1:0]    x_ff, x_in;
   logic [rftd_pkg::MagBits-1:0]    y_ff, y_in;
   logic [rftd_pkg::SumBits-1:0]    acc_ff, acc_in;
   logic [rftd_pkg::SumBits-1:0]    root_ff, root_in;
   logic [rftd_pkg::SumBits-1:0]    bit_ff, bit_in;
   logic [rftd_pkg::StepBits-1:0]   step_ff, step_in;

   logic [rftd_pkg::MagBits-1:0]    operand;
   logic [rftd_pkg::SqBits-1:0]     square;
   logic [rftd_pkg::SumBits:0]      trial;

   // The one multiplier squares x, then y, on successive cycles.
   assign operand = (state_ff == rftd_pkg::US_MUL_X) ? x_ff : y_ff;
   assign square  = operand * operand;

   // Trial subtrahend of the current root digit.
   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};

   // Sequencer: square x, accumulate y squared, then sixteen root steps.
   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      x_in     = x_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      step_in  = step_ff;
      unique case (state_ff)
         rftd_pkg::US_IDLE: begin
            if (start) begin
               x_in     = x_mag;
               y_in     = y_mag;
               state_in = rftd_pkg::US_MUL_X;
            end
         end
         rftd_pkg::US_MUL_X: begin
            acc_in   = {1'b0, square};
            state_in = rftd_pkg::US_MUL_Y;
         end
         rftd_pkg::US_MUL_Y: begin
            acc_in   = acc_ff + {1'b0, square};
            root_in  = '0;
            bit_in   = rftd_pkg::RootBitFirst;
            step_in  = '0;
            state_in = rftd_pkg::US_ROOT;
         end
         rftd_pkg::US_ROOT: begin
            if ({1'b0, acc_ff} >= trial) begin
               acc_in  = acc_ff - trial[rftd_pkg::SumBits-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 1'b1;
            if (step_ff == rftd_pkg::StepLast) begin
               state_in = rftd_pkg::US_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = rftd_pkg::US_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rftd_pkg::US_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      step_ff <= step_in;
   end

   assign stat.busy = (state_ff != rftd_pkg::US_IDLE) || done_ff;
   assign stat.done = done_ff;
   assign root_out  = root_ff[rftd_pkg::DistBits-1:0];

`ifndef ASSERT_OFF
   a_done_after_root: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff) == rftd_pkg::US_ROOT)
      else $error("distance done without a preceding root step");
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == rftd_pkg::US_IDLE) && !done_ff)
      else $error("distance unit started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (state_ff == rftd_pkg::US_IDLE))
      else $error("distance done while the sequencer is still running");
`endif

endmodule

// File: design/radar_frame_target_distance.sv
// Channel  Direction  Fields                                   Beat
// req_bus  in         rx_byte (8)                              one serial byte
// rsp_bus  out        dist_first, dist_second, dist_third (16) one parsed frame
//
// The high y byte of each target hands x and y to the shared distance unit, which
// holds the block not ready until it is through: it squares x and then y on one
// 15x15 multiplier, takes sixteen square-root steps and writes the distance back.
// Synchronous reset returns to header hunting and empties the result register. The
// last frame byte is held off only while the previous result still waits to be
// taken; every other byte is taken regardless of the result side.
module radar_frame_target_distance (
   input  logic        clock,
   input  logic        reset,
   rftd_req_if.sink    req_bus,
   rftd_rsp_if.source  rsp_bus
);

   rftd_pkg::phase_type phase_ff, phase_in;
   logic [rftd_pkg::PosBits-1:0]   pos_ff, pos_in;
   logic [rftd_pkg::ByteBits-1:0]  pend_ff, pend_in;
   logic [rftd_pkg::MagBits-1:0]   xmag_ff, xmag_in;
   logic [rftd_pkg::TgtBits-1:0]   tgt_ff, tgt_in;
   logic [rftd_pkg::DistBits-1:0]  store_ff [rftd_pkg::TgtCount];
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rftd_pkg::DistBits-1:0]  first_ff, second_ff, third_ff;

   logic                           accept;
   logic                           at_last;
   logic                           emit;
   logic                           unit_start;
   logic [rftd_pkg::PosBits-1:0]   rel;
   logic                           in_target;
   logic [rftd_pkg::MagBits-1:0]   ymag;
   logic [rftd_pkg::DistBits-1:0]  unit_dist;
   rftd_pkg::unit_stat_type        stat;

   // Handshake and frame position decode.
   assign accept    = req_bus.valid && req_bus.ready;
   assign at_last   = (phase_ff == rftd_pkg::PH_COLLECT) && (pos_ff == rftd_pkg::FrameLast);
   assign req_bus.ready = !stat.busy && !(at_last && rsp_valid_ff && !rsp_bus.ready);
   assign rel       = pos_ff - rftd_pkg::TargetFirst;
   assign in_target = (pos_ff >= rftd_pkg::TargetFirst) && (pos_ff < rftd_pkg::TargetEnd);
   assign ymag      = {req_bus.rx_byte[rftd_pkg::MagBits-rftd_pkg::ByteBits-1:0], pend_ff};

   // Header hunt and frame collection.
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      pend_in    = pend_ff;
      xmag_in    = xmag_ff;
      tgt_in     = tgt_ff;
      emit       = 1'b0;
      unit_start = 1'b0;
      unique case (phase_ff)
         rftd_pkg::PH_FIRST: begin
            if (accept) begin
               if (req_bus.rx_byte == rftd_pkg::HeaderSecond) begin
                  phase_in = rftd_pkg::PH_COLLECT;
                  pos_in   = '0;
               end else begin
                  phase_in = rftd_pkg::PH_HUNT;
               end
            end
         end
         rftd_pkg::PH_COLLECT: begin
            if (accept) begin
               if (in_target) begin
                  case (rel[rftd_pkg::OffBits-1:0]) inside
                     rftd_pkg::OffXLow, rftd_pkg::OffYLow: begin
                        pend_in = req_bus.rx_byte;
                     end
                     rftd_pkg::OffXHigh: begin
                        xmag_in = ymag;
                     end
                     rftd_pkg::OffYHigh: begin
                        unit_start = 1'b1;
                        tgt_in     = rel[rftd_pkg::PosBits-1:rftd_pkg::OffBits];
                     end
                     default: begin
                     end
                  endcase
               end
               if (at_last) begin
                  emit     = 1'b1;
                  phase_in = rftd_pkg::PH_HUNT;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         default: begin
            // Hunting, and the unused phase code, look for the first header byte.
            if (accept) begin
               phase_in = (req_bus.rx_byte == rftd_pkg::HeaderFirst) ?
                          rftd_pkg::PH_FIRST : rftd_pkg::PH_HUNT;
            end
         end
      endcase
   end

   // Result register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Shared squaring and square-root unit.
   rftd_dist_unit u_dist (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .x_mag    (xmag_ff),
      .y_mag    (ymag),
      .stat     (stat),
      .root_out (unit_dist)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rftd_pkg::PH_HUNT;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Word assembly, distance store and result payload.
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      xmag_ff <= xmag_in;
      tgt_ff  <= tgt_in;
      for (int i = 0; i < rftd_pkg::TgtCount; i++) begin
         if (stat.done && (tgt_ff == rftd_pkg::TgtBits'(i))) begin
            store_ff[i] <= unit_dist;
         end
      end
      if (emit) begin
         first_ff  <= store_ff[0];
         second_ff <= store_ff[1];
         third_ff  <= store_ff[2];
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.dist_first  = first_ff;
   assign rsp_bus.dist_second = second_ff;
   assign rsp_bus.dist_third  = third_ff;

`ifndef ASSERT_OFF
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("frame result would overwrite an untaken beat");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rftd_pkg::PH_COLLECT) |-> (pos_ff <= rftd_pkg::FrameLast))
      else $error("frame position beyond the last frame byte");
   a_start_blocks: assert property (@(posedge clock) disable iff (reset)
      unit_start |=> !req_bus.ready)
      else $error("input still ready after the distance unit started");
   a_done_target: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (tgt_ff == 2'd0 || tgt_ff == 2'd1 || tgt_ff == 2'd2))
      else $error("distance written to a target that does not exist");
`endif

endmodule
